/* src/p2c_pkg.sv */
// ----------------------------------------------------------------------------
// p2c_pkg
// shared constants, types and step functions of the polar to canvas block
// ----------------------------------------------------------------------------
package p2c_pkg;

	// fixed widths and formats
	localparam int COORD_FRAC_BITS  = 8;
	localparam int SLICE_INDEX_BITS = 10;
	localparam int SLICE_CNT_W      = 11;
	localparam int SIZE_W           = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd3;

	// reset values
	localparam logic [SLICE_CNT_W-1:0] SLICE_COUNT_RST = 11'd256;
	localparam logic [SIZE_W-1:0]      LED_COUNT_RST   = 8'd64;
	localparam logic [SIZE_W-1:0]      CANVAS_SIZE_RST = 8'd128;

	// divider: 16 quotient bits, two per stage
	localparam int DIV_W          = 12;
	localparam int QUOT_W         = 16;
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_STAGES     = QUOT_W / DIV_PER_STAGE;

	// cordic: 16 iterations, two per stage
	localparam int CORDIC_STEPS     = 16;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
	localparam int CW               = 18;
	localparam logic signed [CW-1:0] CORDIC_START = 18'sd19898;

	// arctan in units of 1/65536 turn
	localparam logic signed [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163, 18'sd81,
		18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1, 18'sd0
	};

	// control that travels with each transaction
	typedef struct packed {
		logic valid;
		logic err;
	} p2c_ctl_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} p2c_vec_t;

	// one restoring division step, quotient bit on top
	function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
			input logic [DIV_W-1:0] d);
		logic [DIV_W:0] t;
		logic [DIV_W:0] diff;
		t    = {rem, 1'b0};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_step = {1'b1, diff[DIV_W-1:0]};
		end else begin
			div_step = {1'b0, t[DIV_W-1:0]};
		end
	endfunction

	// one cordic rotation step, floor shifts
	function automatic p2c_vec_t cordic_step(input p2c_vec_t v, input int i);
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		p2c_vec_t r;
		dx = v.y >>> i;
		dy = v.x >>> i;
		if (!v.z[CW-1]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - ATAN_TURN[i];
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + ATAN_TURN[i];
		end
		cordic_step = r;
	endfunction

endpackage

/* src/p2c_div.sv */
// ----------------------------------------------------------------------------
// p2c_div
// pipelined restoring dividers for turn phase and radius, two bits a stage
// ----------------------------------------------------------------------------
module p2c_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  p2c_pkg::p2c_ctl_t                     in_ctl,
	input  logic [p2c_pkg::SLICE_INDEX_BITS-1:0]  slice,
	input  logic [p2c_pkg::SIZE_W-1:0]            led,
	input  logic [p2c_pkg::SLICE_CNT_W-1:0]       slice_count,
	input  logic [p2c_pkg::SIZE_W-1:0]            led_count,
	output p2c_pkg::p2c_ctl_t                     out_ctl,
	output logic [p2c_pkg::QUOT_W-1:0]            phase,
	output logic [p2c_pkg::QUOT_W-1:0]            radius
);
	import p2c_pkg::*;

	p2c_ctl_t          ctl_s   [DIV_STAGES+1];
	logic [DIV_W-1:0]  ph_rem_s[DIV_STAGES+1];
	logic [DIV_W-1:0]  rd_rem_s[DIV_STAGES+1];
	logic [QUOT_W-1:0] ph_q_s  [DIV_STAGES+1];
	logic [QUOT_W-1:0] rd_q_s  [DIV_STAGES+1];
	logic [DIV_W-1:0]  ph_d;
	logic [DIV_W-1:0]  rd_d;

	// divisors follow the registers; the user keeps them stable in flight
	assign ph_d = DIV_W'(slice_count);
	assign rd_d = DIV_W'({led_count, 1'b0});

	// numerators: slice and 2*led+1, both below their divisors when in range
	assign ctl_s[0]    = in_ctl;
	assign ph_rem_s[0] = DIV_W'(slice);
	assign rd_rem_s[0] = DIV_W'({led, 1'b1});
	assign ph_q_s[0]   = '0;
	assign rd_q_s[0]   = '0;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DIV_W:0] ph_a, ph_b, rd_a, rd_b;

		// two quotient bits for each divider
		always_comb begin
			ph_a = div_step(ph_rem_s[g], ph_d);
			ph_b = div_step(ph_a[DIV_W-1:0], ph_d);
			rd_a = div_step(rd_rem_s[g], rd_d);
			rd_b = div_step(rd_a[DIV_W-1:0], rd_d);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else if (adv) begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ph_rem_s[g+1] <= ph_b[DIV_W-1:0];
				rd_rem_s[g+1] <= rd_b[DIV_W-1:0];
				ph_q_s[g+1]   <= {ph_q_s[g][QUOT_W-3:0], ph_a[DIV_W], ph_b[DIV_W]};
				rd_q_s[g+1]   <= {rd_q_s[g][QUOT_W-3:0], rd_a[DIV_W], rd_b[DIV_W]};
			end
		end
	end

	assign out_ctl = ctl_s[DIV_STAGES];
	assign phase   = ph_q_s[DIV_STAGES];
	assign radius  = rd_q_s[DIV_STAGES];

endmodule

/* src/p2c_cordic.sv */
// ----------------------------------------------------------------------------
// p2c_cordic
// pipelined rotation cordic giving clamped q1.15 cosine and sine of a phase
// ----------------------------------------------------------------------------
module p2c_cordic (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  p2c_pkg::p2c_ctl_t            in_ctl,
	input  logic [p2c_pkg::QUOT_W-1:0]   phase,
	input  logic [p2c_pkg::QUOT_W-1:0]   radius_in,
	output p2c_pkg::p2c_ctl_t            out_ctl,
	output logic signed [15:0]           cos_q15,
	output logic signed [15:0]           sin_q15,
	output logic [p2c_pkg::QUOT_W-1:0]   radius_out
);
	import p2c_pkg::*;

	p2c_ctl_t          ctl_s [CORDIC_STAGES+1];
	p2c_vec_t          vec_s [CORDIC_STAGES+1];
	logic              flip_s[CORDIC_STAGES+1];
	logic [QUOT_W-1:0] rad_s [CORDIC_STAGES+1];
	logic              flip_in;

	// left half-plane phases turn by half a turn and negate at the end
	assign flip_in = phase[15] ^ phase[14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (adv) begin
			ctl_s[0] <= in_ctl;
		end
	end

	// start vector and folded angle
	always_ff @(posedge clk) begin
		if (adv) begin
			vec_s[0].x <= CORDIC_START;
			vec_s[0].y <= '0;
			vec_s[0].z <= CW'($signed({phase[15] ^ flip_in, phase[14:0]}));
			flip_s[0]  <= flip_in;
			rad_s[0]   <= radius_in;
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		p2c_vec_t v_a, v_b;

		// two micro-rotations a stage
		always_comb begin
			v_a = cordic_step(vec_s[g], CORDIC_PER_STAGE * g);
			v_b = cordic_step(v_a, CORDIC_PER_STAGE * g + 1);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g+1] <= '0;
			end else if (adv) begin
				ctl_s[g+1] <= ctl_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				vec_s[g+1]  <= v_b;
				flip_s[g+1] <= flip_s[g];
				rad_s[g+1]  <= rad_s[g];
			end
		end
	end

	// undo the half turn and saturate to q1.15
	p2c_ctl_t             ctl_q;
	logic signed [CW-1:0] cx, cy;
	logic signed [15:0]   c_q, s_q;
	logic [QUOT_W-1:0]    rad_q;

	assign cx = flip_s[CORDIC_STAGES] ? -vec_s[CORDIC_STAGES].x : vec_s[CORDIC_STAGES].x;
	assign cy = flip_s[CORDIC_STAGES] ? -vec_s[CORDIC_STAGES].y : vec_s[CORDIC_STAGES].y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cx > 18'sd32767) begin
				c_q <= 16'sh7fff;
			end else if (cx < -18'sd32768) begin
				c_q <= 16'sh8000;
			end else begin
				c_q <= cx[15:0];
			end
			if (cy > 18'sd32767) begin
				s_q <= 16'sh7fff;
			end else if (cy < -18'sd32768) begin
				s_q <= 16'sh8000;
			end else begin
				s_q <= cy[15:0];
			end
			rad_q <= rad_s[CORDIC_STAGES];
		end
	end

	assign out_ctl    = ctl_q;
	assign cos_q15    = c_q;
	assign sin_q15    = s_q;
	assign radius_out = rad_q;

endmodule

/* src/p2c_scale.sv */
// ----------------------------------------------------------------------------
// p2c_scale
// radius product, canvas scaling and clamping into the output register
// ----------------------------------------------------------------------------
module p2c_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  p2c_pkg::p2c_ctl_t            in_ctl,
	input  logic signed [15:0]           cos_q15,
	input  logic signed [15:0]           sin_q15,
	input  logic [p2c_pkg::QUOT_W-1:0]   radius,
	input  logic [p2c_pkg::SIZE_W-1:0]   canvas_width,
	input  logic [p2c_pkg::SIZE_W-1:0]   canvas_height,
	output p2c_pkg::p2c_ctl_t            out_ctl,
	output logic [15:0]                  x_fixed,
	output logic [15:0]                  y_fixed
);
	import p2c_pkg::*;

	localparam int PW = 32 + SIZE_W;

	p2c_ctl_t           ctl_s1, ctl_s2, ctl_q;
	logic signed [32:0] tc_s1, ts_s1;
	logic [PW-1:0]      px_s2, py_s2;
	logic [33:0]        nx, ny;
	logic [15:0]        vx, vy, top_x, top_y;
	logic [15:0]        x_q, y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_q  <= '0;
		end else if (adv) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_q  <= ctl_s2;
		end
	end

	// offset by one half; the result stays within 32 unsigned bits
	assign nx = 34'(33'sh0_8000_0000) + 34'(tc_s1);
	assign ny = 34'(33'sh0_8000_0000) - 34'(ts_s1);

	// canvas value and its upper bound
	assign vx    = 16'(px_s2 >> (32 - COORD_FRAC_BITS));
	assign vy    = 16'(py_s2 >> (32 - COORD_FRAC_BITS));
	assign top_x = 16'({canvas_width, COORD_FRAC_BITS'(0)}) - 16'd1;
	assign top_y = 16'({canvas_height, COORD_FRAC_BITS'(0)}) - 16'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			// radius times cosine and sine
			tc_s1 <= $signed({1'b0, radius}) * cos_q15;
			ts_s1 <= $signed({1'b0, radius}) * sin_q15;
			// times canvas size
			px_s2 <= nx[31:0] * canvas_width;
			py_s2 <= ny[31:0] * canvas_height;
			// clamp, zero on index error
			if (ctl_s2.err) begin
				x_q <= '0;
				y_q <= '0;
			end else begin
				x_q <= (vx > top_x) ? top_x : vx;
				y_q <= (vy > top_y) ? top_y : vy;
			end
		end
	end

	assign out_ctl = ctl_q;
	assign x_fixed = x_q;
	assign y_fixed = y_q;

endmodule

/* src/polar_to_canvas_coordinate.sv */
// ----------------------------------------------------------------------------
// polar_to_canvas_coordinate
// maps a rotation slice and led position to an 8.8 canvas point
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled and returns
// one result per transaction, in order. The pipeline holds the input stage,
// the phase and radius dividers (eight stages), the cordic (ten stages) and
// the scaling multipliers (three stages). A stall on the output holds the
// whole pipeline. Registers may be written only when no transaction is in
// flight.
module polar_to_canvas_coordinate (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [p2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [p2c_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [p2c_pkg::SLICE_INDEX_BITS-1:0] slice_index,
	input  logic [7:0]                           led_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [15:0]                          x_fixed,
	output logic [15:0]                          y_fixed,
	output logic                                 index_error
);
	import p2c_pkg::*;

	logic [SLICE_CNT_W-1:0]      slice_count_q;
	logic [SIZE_W-1:0]           led_count_q, width_q, height_q;
	logic                        adv;
	p2c_ctl_t                    ctl_s1, div_ctl, cor_ctl, out_ctl;
	logic [SLICE_INDEX_BITS-1:0] slice_s1;
	logic [7:0]                  led_s1;
	logic [QUOT_W-1:0]           phase, radius, cor_radius;
	logic signed [15:0]          cos_q15, sin_q15;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_count_q <= SLICE_COUNT_RST;
			led_count_q   <= LED_COUNT_RST;
			width_q       <= CANVAS_SIZE_RST;
			height_q      <= CANVAS_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLICE_COUNT:   slice_count_q <= cfg_data;
				REG_LED_COUNT:     led_count_q   <= cfg_data[SIZE_W-1:0];
				REG_CANVAS_WIDTH:  width_q       <= cfg_data[SIZE_W-1:0];
				REG_CANVAS_HEIGHT: height_q      <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves unless a result is held at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// input stage with range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.err   <= (SLICE_CNT_W'(slice_index) >= slice_count_q)
				|| (led_index >= led_count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slice_s1 <= slice_index;
			led_s1   <= led_index;
		end
	end

	p2c_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_ctl     (ctl_s1),
		.slice      (slice_s1),
		.led        (led_s1),
		.slice_count(slice_count_q),
		.led_count  (led_count_q),
		.out_ctl    (div_ctl),
		.phase      (phase),
		.radius     (radius)
	);

	p2c_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_ctl    (div_ctl),
		.phase     (phase),
		.radius_in (radius),
		.out_ctl   (cor_ctl),
		.cos_q15   (cos_q15),
		.sin_q15   (sin_q15),
		.radius_out(cor_radius)
	);

	p2c_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_ctl       (cor_ctl),
		.cos_q15      (cos_q15),
		.sin_q15      (sin_q15),
		.radius       (cor_radius),
		.canvas_width (width_q),
		.canvas_height(height_q),
		.out_ctl      (out_ctl),
		.x_fixed      (x_fixed),
		.y_fixed      (y_fixed)
	);

	assign out_valid   = out_ctl.valid;
	assign index_error = out_ctl.err;

	// an index error gives a zero point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> x_fixed == 16'd0 && y_fixed == 16'd0)
		else $error("index error with non-zero coordinates");

	// coordinates stay below the canvas size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && width_q != '0 |-> x_fixed < {width_q, 8'd0})
		else $error("x beyond canvas width");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && height_q != '0 |-> y_fixed < {height_q, 8'd0})
		else $error("y beyond canvas height");

	// a held result freezes the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(ctl_s1) && $stable(slice_s1))
		else $error("pipeline moved during output stall");

endmodule

/* tb/sv/polar_to_canvas_coordinate_tb.sv */
// ----------------------------------------------------------------------------
// polar_to_canvas_coordinate_tb
// self-checking bench for the polar to canvas coordinate pipeline
// ----------------------------------------------------------------------------
// Items from a queue are driven with random gaps while the output side stalls
// at random. Each accepted transaction is predicted by a fixed-point model
// (turn phase, cordic sine and cosine, radius, canvas scaling and clamping),
// and each result is compared in order. The run goes through several
// register settings, written only while the pipeline is empty.
module polar_to_canvas_coordinate_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import p2c_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [SLICE_INDEX_BITS-1:0] slice;
		logic [7:0]                  led;
	} led_item_t;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic        err;
	} canvas_point_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index   = '0;
	logic [CFG_DATA_W-1:0]       cfg_data    = '0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic [SLICE_INDEX_BITS-1:0] slice_index = '0;
	logic [7:0]                  led_index   = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic [15:0]                 x_fixed;
	logic [15:0]                 y_fixed;
	logic                        index_error;

	// shadow copy of the registers
	int unsigned slices_per_turn = SLICE_COUNT_RST;
	int unsigned leds_per_arm    = LED_COUNT_RST;
	int unsigned canvas_w        = CANVAS_SIZE_RST;
	int unsigned canvas_h        = CANVAS_SIZE_RST;

	led_item_t     pending_leds[$];
	canvas_point_t expected_points[$];
	int            errors     = 0;
	int            cycles     = 0;
	int            send_gap   = 0;
	int            stall_left = 0;
	bit            busy_mode  = 1'b1;

	polar_to_canvas_coordinate u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.slice_index (slice_index),
		.led_index   (led_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.x_fixed     (x_fixed),
		.y_fixed     (y_fixed),
		.index_error (index_error)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// scale (2^31 + term) onto the canvas and clamp
	function automatic logic [15:0] scale_to_canvas(input longint term, input int unsigned size);
		longint num;
		longint v;
		longint top;
		num = 64'sd2147483648 + term;
		if (size == 0) return 16'd0;
		if (num < 0) num = 0;
		v   = (num * longint'(size)) >>> (32 - COORD_FRAC_BITS);
		top = (longint'(size) << COORD_FRAC_BITS) - 1;
		if (v > top) v = top;
		return v[15:0];
	endfunction

	// expected canvas point for one led position
	function automatic void predict_point(input logic [SLICE_INDEX_BITS-1:0] s,
			input logic [7:0] l);
		canvas_point_t p;
		int unsigned   phase;
		longint        radius;
		int            z;
		int            cx;
		int            cy;
		int            dx;
		int            dy;
		bit            flip;
		p = '{16'd0, 16'd0, 1'b1};
		if (s >= slices_per_turn || l >= leds_per_arm) begin
			expected_points.push_back(p);
			return;
		end
		phase  = ((longint'(s) << 16) / slices_per_turn) & 32'hFFFF;
		radius = ((2 * longint'(l) + 1) << 16) / (2 * longint'(leds_per_arm));
		flip   = 1'b0;
		if (phase >= 16384 && phase < 49152) begin
			z    = int'(phase) - 32768;
			flip = 1'b1;
		end else if (phase < 16384) begin
			z = int'(phase);
		end else begin
			z = int'(phase) - 65536;
		end
		cx = CORDIC_START;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z  -= int'(ATAN_TURN[i]);
			end else begin
				cx += dx;
				cy -= dy;
				z  += int'(ATAN_TURN[i]);
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		if (cx > 32767) cx = 32767;
		if (cx < -32768) cx = -32768;
		if (cy > 32767) cy = 32767;
		if (cy < -32768) cy = -32768;
		p.x   = scale_to_canvas(radius * cx, canvas_w);
		p.y   = scale_to_canvas(-(radius * cy), canvas_h);
		p.err = 1'b0;
		expected_points.push_back(p);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!busy_mode || r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_point(slice_index, led_index);
				void'(pending_leds.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_leds.size() > 0) begin
					in_valid    <= 1'b1;
					slice_index <= pending_leds[0].slice;
					led_index   <= pending_leds[0].led;
					send_gap     = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected transaction x=%0d y=%0d err=%0d",
						$time, x_fixed, y_fixed, index_error);
					errors++;
				end else begin
					if (x_fixed !== expected_points[0].x) begin
						$display("%0t: x_fixed expected %0d actual %0d",
							$time, expected_points[0].x, x_fixed);
						errors++;
					end
					if (y_fixed !== expected_points[0].y) begin
						$display("%0t: y_fixed expected %0d actual %0d",
							$time, expected_points[0].y, y_fixed);
						errors++;
					end
					if (index_error !== expected_points[0].err) begin
						$display("%0t: index_error expected %0d actual %0d",
							$time, expected_points[0].err, index_error);
						errors++;
					end
					void'(expected_points.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// register write, shadow copy follows the masking of the block
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_SLICE_COUNT:   slices_per_turn = val & 32'h7FF;
			REG_LED_COUNT:     leds_per_arm    = val & 32'hFF;
			REG_CANVAS_WIDTH:  canvas_w        = val & 32'hFF;
			REG_CANVAS_HEIGHT: canvas_h        = val & 32'hFF;
			default: ;
		endcase
	endtask

	// hold off until every transaction has come out and the pipeline is empty
	task automatic wait_drained();
		while (pending_leds.size() > 0 || expected_points.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned sc, input int unsigned lc,
			input int unsigned w, input int unsigned h);
		wait_drained();
		write_reg(REG_SLICE_COUNT, sc);
		write_reg(REG_LED_COUNT, lc);
		write_reg(REG_CANVAS_WIDTH, w);
		write_reg(REG_CANVAS_HEIGHT, h);
	endtask

	task automatic queue_led(input int unsigned s, input int unsigned l);
		led_item_t it;
		it.slice = s[SLICE_INDEX_BITS-1:0];
		it.led   = l[7:0];
		pending_leds.push_back(it);
	endtask

	// random led positions, mostly inside the configured counts
	task automatic queue_random(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 85 && slices_per_turn > 0 && leds_per_arm > 0) begin
				queue_led($urandom_range(
					(slices_per_turn > 1024 ? 1024 : slices_per_turn) - 1),
					$urandom_range(leds_per_arm - 1));
			end else begin
				queue_led($urandom_range(1023), $urandom_range(255));
			end
		end
		busy_mode = $urandom_range(3) != 0;
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: axes, quadrants and both index limits
		queue_led(0, 0);
		queue_led(64, 63);
		queue_led(128, 32);
		queue_led(192, 10);
		queue_led(255, 63);
		queue_led(32, 63);
		queue_led(96, 63);
		queue_led(160, 63);
		queue_led(224, 63);
		queue_led(256, 0);
		queue_led(0, 64);
		queue_led(1023, 255);
		queue_random(60);

		// full slice index range, largest led count and canvas, outermost ring
		set_geometry(1024, 255, 255, 255);
		queue_led(1023, 254);
		queue_led(0, 254);
		queue_led(256, 254);
		queue_led(512, 254);
		queue_led(768, 254);
		queue_led(128, 0);
		queue_random(70);

		// smallest non-zero everything
		set_geometry(1, 1, 1, 1);
		queue_random(40);
		set_geometry(360, 64, 128, 96);
		queue_random(70);
		// slice count above the index range
		set_geometry(2047, 200, 17, 255);
		queue_random(60);
		// zero counts make every index out of range
		set_geometry(0, 10, 50, 50);
		queue_random(15);
		set_geometry(12, 0, 50, 50);
		queue_random(15);
		// zero canvas
		set_geometry(100, 30, 0, 0);
		queue_random(30);
		// writes to an unused index must leave the registers alone
		wait_drained();
		write_reg(3'd5, 11'h7FF);
		write_reg(3'd7, 11'h001);
		queue_random(30);

		for (int ph = 0; ph < 5; ph++) begin
			set_geometry($urandom_range(1024, 1), $urandom_range(255, 1),
				$urandom_range(255, 1), $urandom_range(255, 1));
			queue_random(60);
		end

		wait_drained();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
src/p2c_pkg.sv
src/p2c_div.sv
src/p2c_cordic.sv
src/p2c_scale.sv
src/polar_to_canvas_coordinate.sv
tb/sv/polar_to_canvas_coordinate_tb.sv
